### design/assert_macros.svh
// Assertion macros used by the top design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define POQ_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

`define POQ_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`else

`define POQ_ASSERT(name, clk, rstn, prop)

`define POQ_ASSERT_ALWAYS(name, clk, prop)

`endif

`endif

### design/poq_pkg.sv
`default_nettype none

package poq_pkg;

  localparam int COORD_W = 16;
  localparam int SIZE_W  = 15;
  localparam int CNT_OUT_W = 7;
  localparam int CFG_IDX_W = 3;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [SIZE_W-1:0]         size_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  localparam logic [CFG_IDX_W-1:0] CFG_BORDER_LOW_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BORDER_LOW_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BORDER_LOW_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BORDER_HIGH_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BORDER_HIGH_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BORDER_HIGH_Z = 3'd5;

  typedef enum logic [0:0] {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef struct packed {
    op_e    op;
    coord_t point_x;
    coord_t point_y;
    coord_t point_z;
    size_t  size_x;
    size_t  size_y;
    size_t  size_z;
  } in_t;

  typedef struct packed {
    logic                 in_obstacle;
    logic                 outside_border;
    logic                 blocked;
    logic                 table_full_error;
    logic [CNT_OUT_W-1:0] box_count;
  } out_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } xyz_t;

  // travels down the cell chain, one cell per cycle unless the chain is stalled
  typedef struct packed {
    op_e  op;
    logic full;
    logic outside;
    logic hit;
    xyz_t pt;
    xyz_t up;
  } tok_t;

  function automatic coord_t sat_upper(coord_t lo, size_t sz);
    logic signed [COORD_W:0] sum;
    sum = {lo[COORD_W-1], lo} + $signed({2'b00, sz});
    if (sum > $signed({1'b0, COORD_MAX})) begin
      return COORD_MAX;
    end
    return sum[COORD_W-1:0];
  endfunction

endpackage

`default_nettype wire

### design/point_obstacle_box_query_top.sv
// Throughput: one item per cycle when not stalled; a query walks the box
// cell chain one cell per cycle and loads travel the same chain to their
// slot, so order holds. An output stall holds the whole chain and stalls
// the input. Reset: box count cleared, border bounds to the full range,
// chain empty; box storage is not cleared.
`default_nettype none
`include "assert_macros.svh"

module point_obstacle_box_query_top #(
  parameter int MAX_BOXES = 64
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire poq_pkg::in_t                       in_data_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output poq_pkg::out_t                           out_data_o,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [poq_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [poq_pkg::COORD_W-1:0]        cfg_data_i
);

  localparam int CNT_W = $clog2(MAX_BOXES + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BOXES);

  poq_pkg::coord_t  lo_x_q, lo_y_q, lo_z_q, hi_x_q, hi_y_q, hi_z_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             adv, in_acc, is_load, full;
  poq_pkg::tok_t    entry_tok;

  logic             vld  [MAX_BOXES+1];
  poq_pkg::tok_t    tok  [MAX_BOXES+1];
  logic [CNT_W-1:0] cnt  [MAX_BOXES+1];
  logic [CNT_W+poq_pkg::CNT_OUT_W-1:0] cnt_ext;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_x_q <= poq_pkg::COORD_MIN;
      lo_y_q <= poq_pkg::COORD_MIN;
      lo_z_q <= poq_pkg::COORD_MIN;
      hi_x_q <= poq_pkg::COORD_MAX;
      hi_y_q <= poq_pkg::COORD_MAX;
      hi_z_q <= poq_pkg::COORD_MAX;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        poq_pkg::CFG_BORDER_LOW_X:  lo_x_q <= cfg_data_i;
        poq_pkg::CFG_BORDER_LOW_Y:  lo_y_q <= cfg_data_i;
        poq_pkg::CFG_BORDER_LOW_Z:  lo_z_q <= cfg_data_i;
        poq_pkg::CFG_BORDER_HIGH_X: hi_x_q <= cfg_data_i;
        poq_pkg::CFG_BORDER_HIGH_Y: hi_y_q <= cfg_data_i;
        poq_pkg::CFG_BORDER_HIGH_Z: hi_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign adv        = !(vld[MAX_BOXES] && out_stall_i);
  assign in_stall_o = !adv;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_load    = in_data_i.op == poq_pkg::OP_LOAD;
  assign full       = cnt_q == MAX_CNT;

  always_comb begin
    cnt_d = cnt_q;
    if (in_acc && is_load && !full) begin
      cnt_d = cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_comb begin
    entry_tok.op      = in_data_i.op;
    entry_tok.full    = is_load && full;
    entry_tok.hit     = 1'b0;
    entry_tok.outside = !is_load && (
        (in_data_i.point_x < lo_x_q) || (in_data_i.point_x > hi_x_q) ||
        (in_data_i.point_y < lo_y_q) || (in_data_i.point_y > hi_y_q) ||
        (in_data_i.point_z < lo_z_q) || (in_data_i.point_z > hi_z_q));
    entry_tok.pt.x    = in_data_i.point_x;
    entry_tok.pt.y    = in_data_i.point_y;
    entry_tok.pt.z    = in_data_i.point_z;
    entry_tok.up.x    = poq_pkg::sat_upper(in_data_i.point_x, in_data_i.size_x);
    entry_tok.up.y    = poq_pkg::sat_upper(in_data_i.point_y, in_data_i.size_y);
    entry_tok.up.z    = poq_pkg::sat_upper(in_data_i.point_z, in_data_i.size_z);
  end

  assign vld[0] = in_acc;
  assign tok[0] = entry_tok;
  assign cnt[0] = cnt_d;

  for (genvar i = 0; i < MAX_BOXES; i++) begin : g_cell
    poq_cell #(
      .CNT_W (CNT_W),
      .IDX   (i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .vld_i  (vld[i]),
      .tok_i  (tok[i]),
      .cnt_i  (cnt[i]),
      .vld_o  (vld[i+1]),
      .tok_o  (tok[i+1]),
      .cnt_o  (cnt[i+1])
    );
  end

  assign cnt_ext = {{poq_pkg::CNT_OUT_W{1'b0}}, cnt[MAX_BOXES]};

  assign out_valid_o                 = vld[MAX_BOXES];
  assign out_data_o.in_obstacle      = tok[MAX_BOXES].hit;
  assign out_data_o.outside_border   = tok[MAX_BOXES].outside;
  assign out_data_o.blocked          = tok[MAX_BOXES].hit || tok[MAX_BOXES].outside;
  assign out_data_o.table_full_error = tok[MAX_BOXES].full;
  assign out_data_o.box_count        = cnt_ext[poq_pkg::CNT_OUT_W-1:0];

  `POQ_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= MAX_CNT)
  `POQ_ASSERT(a_cnt_inc, clk_i, rst_ni,
              (in_acc && is_load && !full) |=> (cnt_q == $past(cnt_q) + CNT_W'(1)))
  `POQ_ASSERT(a_cnt_hold, clk_i, rst_ni, in_stall_o |=> (cnt_q == $past(cnt_q)))
  `POQ_ASSERT(a_full_clean, clk_i, rst_ni,
              (out_valid_o && out_data_o.table_full_error) |->
              (!out_data_o.in_obstacle && !out_data_o.outside_border))

endmodule

`default_nettype wire

### design/poq_cell.sv
`default_nettype none

module poq_cell #(
  parameter int CNT_W = 7,
  parameter int IDX   = 0
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               adv_i,
  input  wire logic               vld_i,
  input  wire poq_pkg::tok_t      tok_i,
  input  wire logic [CNT_W-1:0]   cnt_i,
  output logic                    vld_o,
  output poq_pkg::tok_t           tok_o,
  output logic [CNT_W-1:0]        cnt_o
);

  poq_pkg::xyz_t    lo_q, hi_q;
  logic             vld_q;
  poq_pkg::tok_t    tok_q, tok_d;
  logic [CNT_W-1:0] cnt_q;
  logic             claim, live, enclosed;

  assign claim = vld_i && (tok_i.op == poq_pkg::OP_LOAD) && !tok_i.full &&
                 (cnt_i == CNT_W'(IDX + 1));
  assign live  = cnt_i > CNT_W'(IDX);

  assign enclosed = (tok_i.pt.x > lo_q.x) && (tok_i.pt.x < hi_q.x) &&
                    (tok_i.pt.y > lo_q.y) && (tok_i.pt.y < hi_q.y) &&
                    (tok_i.pt.z > lo_q.z) && (tok_i.pt.z < hi_q.z);

  always_comb begin
    tok_d = tok_i;
    if (tok_i.op == poq_pkg::OP_QUERY && live && enclosed) begin
      tok_d.hit = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      tok_q <= tok_d;
      cnt_q <= cnt_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && claim) begin
      lo_q <= tok_i.pt;
      hi_q <= tok_i.up;
    end
  end

  assign vld_o = vld_q;
  assign tok_o = tok_q;
  assign cnt_o = cnt_q;

endmodule

`default_nettype wire

### sim/point_obstacle_box_query_top_tb.sv
`timescale 1ns / 1ps

module point_obstacle_box_query_top_tb;

  localparam int MAX_BOXES = 64;
  localparam int LATENCY = MAX_BOXES;
  localparam int PHASE_ITEMS = 90;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int NUM_DIRECTED = 19;

  typedef struct {
    poq_pkg::in_t  item;
    bit            fixed;
    poq_pkg::out_t result;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  poq_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  poq_pkg::out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [poq_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [poq_pkg::COORD_W-1:0] cfg_data = '0;

  bit row_fixed = 1'b0;
  poq_pkg::out_t row_result = '0;
  bit no_idle = 1'b0;

  // own copy of the box table and border bounds
  poq_pkg::coord_t box_lo[MAX_BOXES][3];
  poq_pkg::coord_t box_hi[MAX_BOXES][3];
  int box_total = 0;
  poq_pkg::coord_t border_lo[3] = '{poq_pkg::COORD_MIN, poq_pkg::COORD_MIN,
                                    poq_pkg::COORD_MIN};
  poq_pkg::coord_t border_hi[3] = '{poq_pkg::COORD_MAX, poq_pkg::COORD_MAX,
                                    poq_pkg::COORD_MAX};

  poq_pkg::out_t expected_results[$];
  int mismatch_count = 0;
  int stuck_cycles = 0;

  stim_row_t directed_rows[NUM_DIRECTED];

  point_obstacle_box_query_top #(.MAX_BOXES(MAX_BOXES)) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic poq_pkg::coord_t saturated_upper(poq_pkg::coord_t lo,
                                                      poq_pkg::size_t sz);
    int sum;
    sum = int'(lo) + int'(sz);
    if (sum > int'(poq_pkg::COORD_MAX)) begin
      sum = int'(poq_pkg::COORD_MAX);
    end
    return poq_pkg::coord_t'(sum);
  endfunction

  function automatic poq_pkg::out_t predict_box_query(poq_pkg::in_t item);
    poq_pkg::out_t r;
    poq_pkg::coord_t p[3];
    poq_pkg::size_t s[3];
    bit enclosed;
    r = '0;
    p = '{item.point_x, item.point_y, item.point_z};
    s = '{item.size_x, item.size_y, item.size_z};
    if (item.op == poq_pkg::OP_LOAD) begin
      if (box_total >= MAX_BOXES) begin
        r.table_full_error = 1'b1;
      end else begin
        for (int a = 0; a < 3; a++) begin
          box_lo[box_total][a] = p[a];
          box_hi[box_total][a] = saturated_upper(p[a], s[a]);
        end
        box_total++;
      end
    end else begin
      for (int a = 0; a < 3; a++) begin
        if (p[a] < border_lo[a] || p[a] > border_hi[a]) begin
          r.outside_border = 1'b1;
        end
      end
      for (int i = 0; i < box_total; i++) begin
        enclosed = 1'b1;
        for (int a = 0; a < 3; a++) begin
          if (!(p[a] > box_lo[i][a] && p[a] < box_hi[i][a])) begin
            enclosed = 1'b0;
          end
        end
        if (enclosed) begin
          r.in_obstacle = 1'b1;
        end
      end
      r.blocked = r.in_obstacle | r.outside_border;
    end
    r.box_count = 7'(box_total);
    return r;
  endfunction

  function automatic void check_field(string name, logic [6:0] want, logic [6:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  function automatic poq_pkg::coord_t rand_span(int lo, int hi);
    return poq_pkg::coord_t'(lo + int'($urandom_range(0, hi - lo)));
  endfunction

  function automatic stim_row_t mk_row(poq_pkg::op_e op, int x, int y, int z, int sx,
                                       int sy, int sz, bit fixed, poq_pkg::out_t res);
    stim_row_t row;
    row.item.op = op;
    row.item.point_x = poq_pkg::coord_t'(x);
    row.item.point_y = poq_pkg::coord_t'(y);
    row.item.point_z = poq_pkg::coord_t'(z);
    row.item.size_x = poq_pkg::size_t'(sx);
    row.item.size_y = poq_pkg::size_t'(sy);
    row.item.size_z = poq_pkg::size_t'(sz);
    row.fixed = fixed;
    row.result = res;
    return row;
  endfunction

  function automatic poq_pkg::in_t random_item();
    poq_pkg::in_t it;
    poq_pkg::coord_t p[3];
    poq_pkg::size_t s[3];
    int mode;
    int b;
    int l;
    int u;
    bit hit_try;
    if ($urandom_range(0, 99) < 30) begin
      it.op = poq_pkg::OP_LOAD;
      for (int a = 0; a < 3; a++) begin
        p[a] = ($urandom_range(0, 9) < 2) ? poq_pkg::coord_t'($urandom)
                                           : rand_span(-4000, 4000);
        case ($urandom_range(0, 9))
          0: s[a] = '0;
          1: s[a] = poq_pkg::size_t'($urandom);
          2: s[a] = '1;
          default: s[a] = poq_pkg::size_t'($urandom_range(1, 2000));
        endcase
      end
    end else begin
      it.op = poq_pkg::OP_QUERY;
      mode = $urandom_range(0, 99);
      b = (box_total > 0) ? $urandom_range(0, box_total - 1) : 0;
      hit_try = $urandom_range(0, 1);
      for (int a = 0; a < 3; a++) begin
        s[a] = poq_pkg::size_t'($urandom);
        if (mode < 45 && box_total > 0) begin
          l = int'(box_lo[b][a]);
          u = int'(box_hi[b][a]);
          case (hit_try ? 6 : $urandom_range(0, 11))
            0: p[a] = poq_pkg::coord_t'(l - 1);
            1: p[a] = poq_pkg::coord_t'(l);
            2: p[a] = poq_pkg::coord_t'(l + 1);
            3: p[a] = poq_pkg::coord_t'(u - 1);
            4: p[a] = poq_pkg::coord_t'(u);
            5: p[a] = poq_pkg::coord_t'(u + 1);
            default: p[a] = rand_span(l, u);
          endcase
        end else if (mode < 70) begin
          l = int'(border_lo[a]);
          u = int'(border_hi[a]);
          case ($urandom_range(0, 6))
            0: p[a] = poq_pkg::coord_t'(l - 1);
            1: p[a] = poq_pkg::coord_t'(l);
            2: p[a] = poq_pkg::coord_t'(l + 1);
            3: p[a] = poq_pkg::coord_t'(u - 1);
            4: p[a] = poq_pkg::coord_t'(u);
            5: p[a] = poq_pkg::coord_t'(u + 1);
            default: p[a] = poq_pkg::coord_t'($urandom);
          endcase
        end else begin
          p[a] = poq_pkg::coord_t'($urandom);
        end
      end
    end
    it.point_x = p[0];
    it.point_y = p[1];
    it.point_z = p[2];
    it.size_x = s[0];
    it.size_y = s[1];
    it.size_z = s[2];
    return it;
  endfunction

  // called at a falling edge; returns at the falling edge after the beat
  task automatic send_item(poq_pkg::in_t item, bit fixed, poq_pkg::out_t res);
    while (!no_idle && $urandom_range(0, 99) < 27) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    row_fixed <= fixed;
    row_result <= res;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_border(logic [poq_pkg::CFG_IDX_W-1:0] idx, poq_pkg::coord_t value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_borders(poq_pkg::coord_t lx, poq_pkg::coord_t ly, poq_pkg::coord_t lz,
                             poq_pkg::coord_t hx, poq_pkg::coord_t hy, poq_pkg::coord_t hz);
    write_border(poq_pkg::CFG_BORDER_LOW_X, lx);
    write_border(poq_pkg::CFG_BORDER_LOW_Y, ly);
    write_border(poq_pkg::CFG_BORDER_LOW_Z, lz);
    write_border(poq_pkg::CFG_BORDER_HIGH_X, hx);
    write_border(poq_pkg::CFG_BORDER_HIGH_Y, hy);
    write_border(poq_pkg::CFG_BORDER_HIGH_Z, hz);
    cfg_valid <= 1'b0;
  endtask

  always @(negedge clk) begin
    out_stall <= !no_idle && ($urandom_range(0, 99) < 27);
  end

  always @(posedge clk) begin
    poq_pkg::out_t predicted;
    poq_pkg::out_t want;
    bit any_beat;
    if (rst_n) begin
      any_beat = 1'b0;
      if (out_valid && !out_stall) begin
        any_beat = 1'b1;
        if (expected_results.size() == 0) begin
          $display("%0t: result beat with nothing expected, got %p", $time, out_data);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("in_obstacle", want.in_obstacle, out_data.in_obstacle);
          check_field("outside_border", want.outside_border, out_data.outside_border);
          check_field("blocked", want.blocked, out_data.blocked);
          check_field("table_full_error", want.table_full_error, out_data.table_full_error);
          check_field("box_count", want.box_count, out_data.box_count);
        end
      end
      if (cfg_valid && cfg_ready) begin
        any_beat = 1'b1;
        case (cfg_index)
          poq_pkg::CFG_BORDER_LOW_X:  border_lo[0] = poq_pkg::coord_t'(cfg_data);
          poq_pkg::CFG_BORDER_LOW_Y:  border_lo[1] = poq_pkg::coord_t'(cfg_data);
          poq_pkg::CFG_BORDER_LOW_Z:  border_lo[2] = poq_pkg::coord_t'(cfg_data);
          poq_pkg::CFG_BORDER_HIGH_X: border_hi[0] = poq_pkg::coord_t'(cfg_data);
          poq_pkg::CFG_BORDER_HIGH_Y: border_hi[1] = poq_pkg::coord_t'(cfg_data);
          poq_pkg::CFG_BORDER_HIGH_Z: border_hi[2] = poq_pkg::coord_t'(cfg_data);
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        any_beat = 1'b1;
        predicted = predict_box_query(in_data);
        expected_results.push_back(row_fixed ? row_result : predicted);
      end
      stuck_cycles = any_beat ? 0 : stuck_cycles + 1;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, stuck_cycles);
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    poq_pkg::coord_t vx;
    poq_pkg::coord_t vy;
    poq_pkg::coord_t vz;
    directed_rows[0]  = mk_row(poq_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0, 1,
                               '{1'b0, 1'b0, 1'b0, 1'b0, 7'd0});
    directed_rows[1]  = mk_row(poq_pkg::OP_QUERY, -32768, 32767, -32768, 32767, 32767,
                               32767, 1, '{1'b0, 1'b0, 1'b0, 1'b0, 7'd0});
    directed_rows[2]  = mk_row(poq_pkg::OP_LOAD, 0, 0, 0, 100, 100, 100, 1,
                               '{1'b0, 1'b0, 1'b0, 1'b0, 7'd1});
    directed_rows[3]  = mk_row(poq_pkg::OP_QUERY, 50, 50, 50, 0, 0, 0, 1,
                               '{1'b1, 1'b0, 1'b1, 1'b0, 7'd1});
    directed_rows[4]  = mk_row(poq_pkg::OP_QUERY, 0, 50, 50, 0, 0, 0, 1,
                               '{1'b0, 1'b0, 1'b0, 1'b0, 7'd1});
    directed_rows[5]  = mk_row(poq_pkg::OP_QUERY, 100, 50, 50, 0, 0, 0, 1,
                               '{1'b0, 1'b0, 1'b0, 1'b0, 7'd1});
    directed_rows[6]  = mk_row(poq_pkg::OP_QUERY, 99, 1, 99, 0, 0, 0, 1,
                               '{1'b1, 1'b0, 1'b1, 1'b0, 7'd1});
    // upper corner saturates on x
    directed_rows[7]  = mk_row(poq_pkg::OP_LOAD, 32700, -32768, -32768, 32767, 32767,
                               32767, 1, '{1'b0, 1'b0, 1'b0, 1'b0, 7'd2});
    directed_rows[8]  = mk_row(poq_pkg::OP_QUERY, 32766, -2, -2, 0, 0, 0, 1,
                               '{1'b1, 1'b0, 1'b1, 1'b0, 7'd2});
    directed_rows[9]  = mk_row(poq_pkg::OP_QUERY, 32767, -2, -2, 0, 0, 0, 1,
                               '{1'b0, 1'b0, 1'b0, 1'b0, 7'd2});
    // empty boxes: zero size, and saturated onto the lower corner
    directed_rows[10] = mk_row(poq_pkg::OP_LOAD, 1000, 1000, 1000, 0, 50, 50, 1,
                               '{1'b0, 1'b0, 1'b0, 1'b0, 7'd3});
    directed_rows[11] = mk_row(poq_pkg::OP_QUERY, 1000, 1010, 1010, 0, 0, 0, 1,
                               '{1'b0, 1'b0, 1'b0, 1'b0, 7'd3});
    directed_rows[12] = mk_row(poq_pkg::OP_LOAD, 32767, 0, 0, 5, 5, 5, 1,
                               '{1'b0, 1'b0, 1'b0, 1'b0, 7'd4});
    directed_rows[13] = mk_row(poq_pkg::OP_QUERY, 32767, 2, 2, 0, 0, 0, 1,
                               '{1'b0, 1'b0, 1'b0, 1'b0, 7'd4});
    directed_rows[14] = mk_row(poq_pkg::OP_LOAD, -32768, -32768, -32768, 32767, 32767,
                               32767, 1, '{1'b0, 1'b0, 1'b0, 1'b0, 7'd5});
    directed_rows[15] = mk_row(poq_pkg::OP_QUERY, -32767, -32767, -32767, 0, 0, 0, 1,
                               '{1'b1, 1'b0, 1'b1, 1'b0, 7'd5});
    directed_rows[16] = mk_row(poq_pkg::OP_QUERY, -2, -2, -2, 32767, 32767, 32767, 1,
                               '{1'b1, 1'b0, 1'b1, 1'b0, 7'd5});
    directed_rows[17] = mk_row(poq_pkg::OP_QUERY, -1, -1, -1, 0, 0, 0, 1,
                               '{1'b0, 1'b0, 1'b0, 1'b0, 7'd5});
    directed_rows[18] = mk_row(poq_pkg::OP_QUERY, 32767, 32767, 32767, 0, 0, 0, 1,
                               '{1'b0, 1'b0, 1'b0, 1'b0, 7'd5});

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].item, directed_rows[i].fixed, directed_rows[i].result);
    end

    for (int ph = 1; ph <= 6; ph++) begin
      drain_results();
      case (ph)
        1: set_borders(rand_span(-6000, 0), rand_span(-6000, 0), rand_span(-6000, 0),
                       rand_span(0, 6000), rand_span(0, 6000), rand_span(0, 6000));
        // crossed bounds: every point is outside
        2: set_borders(poq_pkg::COORD_MAX, poq_pkg::COORD_MAX, poq_pkg::COORD_MAX,
                       poq_pkg::COORD_MIN, poq_pkg::COORD_MIN, poq_pkg::COORD_MIN);
        3: set_borders(poq_pkg::COORD_MIN, poq_pkg::COORD_MIN, poq_pkg::COORD_MIN,
                       poq_pkg::COORD_MAX, poq_pkg::COORD_MAX, poq_pkg::COORD_MAX);
        4: begin
          vx = rand_span(-200, 200);
          vy = rand_span(-200, 200);
          vz = rand_span(-200, 200);
          set_borders(vx, vy, vz, vx, vy, vz);
        end
        5: set_borders(poq_pkg::coord_t'($urandom), poq_pkg::coord_t'($urandom),
                       poq_pkg::coord_t'($urandom), poq_pkg::coord_t'($urandom),
                       poq_pkg::coord_t'($urandom), poq_pkg::coord_t'($urandom));
        default: set_borders(poq_pkg::COORD_MIN, rand_span(-3000, 0),
                             rand_span(-3000, 3000), poq_pkg::COORD_MAX,
                             rand_span(0, 3000), rand_span(-3000, 3000));
      endcase
      no_idle = (ph == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 4 && n == PHASE_ITEMS / 2) begin
          drain_results();
        end
        send_item(random_item(), 1'b0, '0);
      end
    end

    no_idle = 1'b0;
    drain_results();
    repeat (2 * LATENCY) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
